// ----- hdl/edq_pkg.sv -----
package edq_pkg;

  localparam int CFG_W = 13;
  localparam int ROW_W = 12;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [1:0] CFG_LEVEL_BITS   = 2'd0;
  localparam logic [1:0] CFG_LINE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic [3:0] W_RIGHT       = 4'd7;
  localparam logic [3:0] W_BELOW_LEFT  = 4'd3;
  localparam logic [3:0] W_BELOW       = 4'd5;
  localparam logic [3:0] W_BELOW_RIGHT = 4'd1;

  localparam logic [7:0] PIX_MAX = 8'd255;

  typedef logic signed [9:0] err_t;
  typedef logic signed [8:0] qerr_t;

  typedef struct packed {
    logic       op;
    logic [7:0] pixel_in;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_row;
    logic       end_of_frame;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR0,
    ST_WR1,
    ST_WR2,
    ST_DONE
  } edq_state_t;

  typedef struct packed {
    logic take;
    logic rd0;
    logic rd1;
    logic rd2;
    logic wr0;
    logic wr1;
    logic wr2;
    logic finish;
  } edq_cmd_t;

  typedef struct packed {
    logic is_table;
    logic out_free;
  } edq_sts_t;

  typedef logic [7:0] qrom_t [0:2047];

  // nearest level for every level count and every gamma value, ties go up
  function automatic qrom_t build_qrom();
    qrom_t t;
    int    lv [0:255];
    int    n;
    int    k;
    int    parts;
    int    spare;
    int    d;
    int    r;
    int    cur;
    int    i;
    int    q;
    for (int b = 1; b <= 8; b++) begin
      n = 1 << b;
      if (n == 256) begin
        for (int j = 0; j < 256; j++) lv[j] = j;
      end else begin
        k = n - 2;
        parts = k + 1;
        spare = 254 - k;
        d = 0;
        r = spare;
        while (r >= parts) begin
          r = r - parts;
          d = d + 1;
        end
        lv[0] = 0;
        cur = 1;
        for (int j = 1; j <= k; j++) begin
          cur = cur + d;
          if (r > 0) begin
            cur = cur + 1;
            r = r - 1;
          end
          lv[j] = cur & 255;
        end
        lv[k + 1] = 255;
      end
      i = 0;
      for (int v = 0; v < 256; v++) begin
        while (i + 1 < n && lv[i] < v) i = i + 1;
        if (lv[i] == v || i == 0) begin
          q = lv[i];
        end else if (v - lv[i - 1] < lv[i] - v) begin
          q = lv[i - 1];
        end else begin
          q = lv[i];
        end
        t[(b - 1) * 256 + v] = 8'(q);
      end
    end
    return t;
  endfunction

  localparam qrom_t QROM = build_qrom();

  // trunc((16*old + w*e) / 16) toward zero
  function automatic err_t spread(input err_t old, input logic [3:0] wgt, input qerr_t e);
    logic signed [15:0] t;
    logic signed [15:0] ta;
    t  = (16'(old) <<< 4) + 16'(e) * $signed({12'd0, wgt});
    ta = t + (t[15] ? 16'sd15 : 16'sd0);
    return 10'(ta >>> 4);
  endfunction

endpackage

// ----- hdl/edq_ctrl.sv -----
module edq_ctrl import edq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  edq_sts_t sts,
  output edq_cmd_t cmd
);

  edq_state_t state_r;
  edq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !sts.is_table) state_nxt = ST_RD0;
      end
      ST_RD0: state_nxt = ST_RD1;
      ST_RD1: state_nxt = ST_RD2;
      ST_RD2: state_nxt = ST_WR0;
      ST_WR0: state_nxt = ST_WR1;
      ST_WR1: state_nxt = ST_WR2;
      ST_WR2: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_RD0: cmd.rd0 = 1'b1;
      ST_RD1: cmd.rd1 = 1'b1;
      ST_RD2: cmd.rd2 = 1'b1;
      ST_WR0: cmd.wr0 = 1'b1;
      ST_WR1: cmd.wr1 = 1'b1;
      ST_WR2: cmd.wr2 = 1'b1;
      ST_DONE: cmd.finish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/edq_dp.sv -----
module edq_dp import edq_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_beat_t         in_data,
  output out_beat_t        out_data,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  edq_cmd_t         cmd,
  output edq_sts_t         sts
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int FW = $clog2(MAX_WIDTH + 1);
  localparam int CW = (FW > CFG_W) ? FW : CFG_W;

  logic [3:0]       level_bits_r;
  logic [CFG_W-1:0] line_width_r;
  logic [CFG_W-1:0] frame_height_r;

  logic [AW-1:0]    cc_r;
  logic [ROW_W-1:0] rc_r;
  logic             sel_r;
  logic [FW-1:0]    fill0_r;
  logic [FW-1:0]    fill1_r;

  err_t       mem0 [MAX_WIDTH];
  err_t       mem1 [MAX_WIDTH];
  logic [7:0] gmem [256];

  err_t       rd0_r;
  err_t       rd1_r;
  logic       rv0_r;
  logic       rv1_r;
  logic [7:0] g_rd_r;
  logic [7:0] q_rd_r;

  logic [7:0] pix_r;
  err_t       e_nl_r;
  err_t       e_nc_r;
  err_t       e_nr_r;
  err_t       e_cr_r;
  logic [7:0] q_r;
  qerr_t      err_r;

  out_beat_t  out_r;
  logic       out_valid_r;

  logic [CW-1:0]    w_eff;
  logic [CW-1:0]    w_m1;
  logic [CFG_W-1:0] h_eff;
  logic [AW-1:0]    col;
  logic [AW-1:0]    col_p1;
  logic [AW-1:0]    col_m1;
  logic             last_col;
  logic             right_ok;
  logic             last_row;
  logic [2:0]       bsel;

  logic [AW-1:0] cur_ra;
  logic [AW-1:0] nxt_ra;
  logic [AW-1:0] ra0;
  logic [AW-1:0] ra1;
  err_t          q0;
  err_t          q1;
  err_t          cur_q;
  err_t          nxt_q;

  logic          cur_we;
  logic [AW-1:0] cur_wa;
  err_t          cur_wd;
  logic          nxt_we;
  logic [AW-1:0] nxt_wa;
  err_t          nxt_wd;
  logic          we0;
  logic [AW-1:0] wa0;
  err_t          wd0;
  logic          we1;
  logic [AW-1:0] wa1;
  err_t          wd1;

  logic signed [10:0] sum;
  logic [7:0]         g_ra;

  // effective sizes
  always_comb begin
    if (line_width_r == '0) begin
      w_eff = CW'(1);
    end else if (CW'(line_width_r) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(line_width_r);
    end
    w_m1 = w_eff - CW'(1);
    if (frame_height_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (frame_height_r > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
    if (level_bits_r == 4'd0) begin
      bsel = 3'd0;
    end else if (level_bits_r > 4'd8) begin
      bsel = 3'd7;
    end else begin
      bsel = 3'(level_bits_r - 4'd1);
    end
    col      = (CW'(cc_r) > w_m1) ? AW'(w_m1) : cc_r;
    col_p1   = col + AW'(1);
    col_m1   = col - AW'(1);
    last_col = (CW'(col) >= w_m1);
    right_ok = (CW'(col) + CW'(1) < w_eff);
    last_row = ({1'b0, rc_r} >= h_eff - CFG_W'(1));
  end

  // logical read addresses
  always_comb begin
    cur_ra = col;
    nxt_ra = col;
    if (cmd.rd0) begin
      nxt_ra = col_m1;
    end else if (cmd.rd1) begin
      cur_ra = col_p1;
    end else if (cmd.rd2) begin
      nxt_ra = col_p1;
    end
    ra0 = sel_r ? nxt_ra : cur_ra;
    ra1 = sel_r ? cur_ra : nxt_ra;
    q0 = rv0_r ? rd0_r : '0;
    q1 = rv1_r ? rd1_r : '0;
    cur_q = sel_r ? q1 : q0;
    nxt_q = sel_r ? q0 : q1;
  end

  // logical writes
  always_comb begin
    cur_we = 1'b0;
    cur_wa = col_p1;
    cur_wd = spread(e_cr_r, W_RIGHT, err_r);
    nxt_we = 1'b0;
    nxt_wa = col;
    nxt_wd = spread(e_nc_r, W_BELOW, err_r);
    if (cmd.wr0) begin
      cur_we = right_ok;
      nxt_we = (col != '0);
      nxt_wa = col_m1;
      nxt_wd = spread(e_nl_r, W_BELOW_LEFT, err_r);
    end else if (cmd.wr1) begin
      nxt_we = 1'b1;
    end else if (cmd.wr2) begin
      nxt_we = right_ok;
      nxt_wa = col_p1;
      nxt_wd = spread(e_nr_r, W_BELOW_RIGHT, err_r);
    end
    we0 = sel_r ? nxt_we : cur_we;
    wa0 = sel_r ? nxt_wa : cur_wa;
    wd0 = sel_r ? nxt_wd : cur_wd;
    we1 = sel_r ? cur_we : nxt_we;
    wa1 = sel_r ? cur_wa : nxt_wa;
    wd1 = sel_r ? cur_wd : nxt_wd;
  end

  // pixel plus diffused error, clamped
  always_comb begin
    sum = $signed({3'b000, pix_r}) + 11'(cur_q);
    if (sum < 0) begin
      g_ra = 8'd0;
    end else if (sum > $signed({3'b000, PIX_MAX})) begin
      g_ra = PIX_MAX;
    end else begin
      g_ra = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we0) mem0[wa0] <= wd0;
    rd0_r <= mem0[ra0];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wa1] <= wd1;
    rd1_r <= mem1[ra1];
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_data.op) gmem[in_data.table_index] <= in_data.table_value;
    g_rd_r <= gmem[g_ra];
    q_rd_r <= QROM[{bsel, g_rd_r}];
  end

  always_ff @(posedge clk) begin
    rv0_r <= (FW'(ra0) < fill0_r);
    rv1_r <= (FW'(ra1) < fill1_r);
    if (cmd.take) pix_r <= in_data.pixel_in;
    if (cmd.rd1) e_nl_r <= nxt_q;
    if (cmd.rd2) begin
      e_cr_r <= cur_q;
      e_nc_r <= nxt_q;
      q_r    <= q_rd_r;
      err_r  <= $signed({1'b0, g_rd_r}) - $signed({1'b0, q_rd_r});
    end
    if (cmd.wr0) e_nr_r <= nxt_q;
    if (cmd.finish) begin
      out_r.pixel_out    <= q_r;
      out_r.end_of_row   <= last_col;
      out_r.end_of_frame <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_bits_r   <= 4'd1;
      line_width_r   <= CFG_W'(640);
      frame_height_r <= CFG_W'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEVEL_BITS:   level_bits_r   <= cfg_data[3:0];
        CFG_LINE_WIDTH:   line_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= '0;
      rc_r        <= '0;
      sel_r       <= 1'b0;
      fill0_r     <= '0;
      fill1_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (we0 && FW'(wa0) >= fill0_r) fill0_r <= FW'(wa0) + FW'(1);
      if (we1 && FW'(wa1) >= fill1_r) fill1_r <= FW'(wa1) + FW'(1);
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        if (last_col) begin
          cc_r <= '0;
          if (last_row) begin
            rc_r    <= '0;
            fill0_r <= '0;
            fill1_r <= '0;
          end else begin
            rc_r  <= rc_r + ROW_W'(1);
            sel_r <= ~sel_r;
            // old current store becomes the fresh next-row store
            if (sel_r) begin
              fill1_r <= '0;
            end else begin
              fill0_r <= '0;
            end
          end
        end else begin
          cc_r <= col_p1;
        end
      end
    end
  end

  assign out_data     = out_r;
  assign out_valid    = out_valid_r;
  assign sts.is_table = in_data.op;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// ----- hdl/error_diffusion_quantizer_top.sv -----
// Floyd-Steinberg error diffusion quantizer for 8-bit grey pixels in raster order. A pixel beat
// (op 0) returns one quantized pixel with end-of-row and end-of-frame flags; a table beat (op 1)
// loads one gamma table entry, must precede any pixel that reads that entry, and returns nothing.
// A pixel walks RD0, RD1, RD2, WR0, WR1, WR2 and DONE before out_valid rises, and the next beat
// is taken only back in IDLE; a pixel holds the block for that walk, set by the single read and
// write port of each error line store: five reads and four read-modify-writes per pixel.
// A new beat is taken while the previous result still waits on out_stall. Error line stores
// need no clearing pass; row and frame ends take effect at once. cfg_ready is always high;
// registers may be written only while the block is idle.
module error_diffusion_quantizer_top import edq_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  edq_cmd_t cmd;
  edq_sts_t sts;

  assign cfg_ready = 1'b1;

  edq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  edq_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- tb/tb.sv -----
module tb import edq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_TABLE = 1'b1;
  localparam int LINE_MAX = 4096;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_beat_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  error_diffusion_quantizer_top dut (.*);

  // predictor state
  int unsigned lvl_bits_reg;
  int unsigned width_reg;
  int unsigned height_reg;
  int          cur_err [LINE_MAX];
  int          nxt_err [LINE_MAX];
  logic [7:0]  gamma_lut [256];
  int unsigned col_cnt;
  int unsigned row_cnt;

  out_beat_t expected_pix [$];
  int        n_fail = 0;
  int        snd_pct;
  int        rcv_pct;
  longint    cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int diffuse(int old, int wgt, int e);
    return (old * 16 + wgt * e) / 16;
  endfunction

  function automatic logic [7:0] nearest_level(int unsigned bits, int v);
    int lv [256];
    int n;
    int k;
    int d;
    int r;
    int acc;
    int i;
    if (bits < 1) bits = 1;
    if (bits > 8) bits = 8;
    n = 1 << bits;
    if (n == 256) return 8'(v);
    k = n - 2;
    d = (254 - k) / (k + 1);
    r = (254 - k) % (k + 1);
    lv[0] = 0;
    acc = 1;
    for (int j = 1; j <= k; j++) begin
      acc = acc + d;
      if (r > 0) begin
        acc++;
        r--;
      end
      lv[j] = acc & 255;
    end
    lv[k + 1] = 255;
    i = 0;
    while (i + 1 < n && lv[i] < v) i++;
    if (lv[i] == v || i == 0) return 8'(lv[i]);
    return (v - lv[i - 1] < lv[i] - v) ? 8'(lv[i - 1]) : 8'(lv[i]);
  endfunction

  function automatic out_beat_t dither_pixel(logic [7:0] px);
    out_beat_t res;
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int sum;
    int v;
    int e;
    w = (width_reg < 1) ? 1 : (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
    h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    col = (col_cnt > w - 1) ? w - 1 : col_cnt;
    sum = int'(px) + cur_err[col];
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    v = gamma_lut[sum];
    res.pixel_out = nearest_level(lvl_bits_reg, v);
    e = v - int'(res.pixel_out);
    nxt_err[col] = diffuse(nxt_err[col], W_BELOW, e);
    if (col > 0) nxt_err[col - 1] = diffuse(nxt_err[col - 1], W_BELOW_LEFT, e);
    if (col + 1 < w) begin
      cur_err[col + 1] = diffuse(cur_err[col + 1], W_RIGHT, e);
      nxt_err[col + 1] = diffuse(nxt_err[col + 1], W_BELOW_RIGHT, e);
    end
    res.end_of_row = 1'b0;
    res.end_of_frame = 1'b0;
    if (col >= w - 1) begin
      res.end_of_row = 1'b1;
      col_cnt = 0;
      if (row_cnt >= h - 1) begin
        res.end_of_frame = 1'b1;
        row_cnt = 0;
        foreach (cur_err[j]) cur_err[j] = 0;
      end else begin
        row_cnt = (row_cnt + 1) & 12'hfff;
        cur_err = nxt_err;
      end
      foreach (nxt_err[j]) nxt_err[j] = 0;
    end else begin
      col_cnt = col + 1;
    end
    return res;
  endfunction

  // drive one beat; returns once it is accepted
  task automatic send_beat(in_beat_t b, bit use_typed = 0, out_beat_t typed = '0);
    out_beat_t p;
    while ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    if (b.op == OP_TABLE) begin
      gamma_lut[b.table_index] = b.table_value;
    end else begin
      p = dither_pixel(b.pixel_in);
      if (use_typed) p = typed;
      expected_pix = {expected_pix, p};
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEVEL_BITS:   lvl_bits_reg = val & 4'hf;
      CFG_LINE_WIDTH:   width_reg = val;
      CFG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_mode(int m);
    case (m)
      0: begin snd_pct = 0;  rcv_pct = 0;  end
      1: begin snd_pct = 85; rcv_pct = 0;  end
      2: begin snd_pct = 0;  rcv_pct = 85; end
      default: begin snd_pct = 9; rcv_pct = 9; end
    endcase
  endtask

  function automatic in_beat_t pix(logic [7:0] v);
    in_beat_t b;
    b = '0;
    b.op = OP_PIXEL;
    b.pixel_in = v;
    b.table_index = ~v;
    b.table_value = v ^ 8'h5a;
    return b;
  endfunction

  function automatic in_beat_t tbl(logic [7:0] idx, logic [7:0] val);
    in_beat_t b;
    b.op = OP_TABLE;
    b.pixel_in = ~idx;
    b.table_index = idx;
    b.table_value = val;
    return b;
  endfunction

  // directed beats; first rows have results readable at a glance
  in_beat_t  dir_beat [];
  bit        dir_has  [];
  out_beat_t dir_exp  [];

  // level_bits, line_width, frame_height, beats, idle mode
  int phase_cfg [10][5] = '{
    '{8, 1, 1, 150, 0},
    '{3, 5, 4, 150, 1},
    '{4, 17, 3, 150, 2},
    '{2, 4096, 2, 150, 3},
    '{0, 0, 0, 150, 0},
    '{15, 8191, 8191, 100, 1},
    '{5, 7, 9, 200, 2},
    '{6, 2, 4096, 150, 3},
    '{7, 33, 2, 200, 0},
    '{1, 3, 5, 150, 1}
  };

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pix.size() == 0) begin
          $display("%0t: unexpected pixel %p", $time, out_data);
          n_fail++;
        end else begin
          out_beat_t e;
          e = expected_pix.pop_front();
          if (out_data.pixel_out !== e.pixel_out) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel_out,
                     out_data.pixel_out);
            n_fail++;
          end
          if (out_data.end_of_row !== e.end_of_row) begin
            $display("%0t: end_of_row expected %0b actual %0b", $time, e.end_of_row,
                     out_data.end_of_row);
            n_fail++;
          end
          if (out_data.end_of_frame !== e.end_of_frame) begin
            $display("%0t: end_of_frame expected %0b actual %0b", $time, e.end_of_frame,
                     out_data.end_of_frame);
            n_fail++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("error_diffusion_quantizer_top regression: fail");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    lvl_bits_reg = 1;
    width_reg = 640;
    height_reg = 480;
    foreach (cur_err[j]) begin
      cur_err[j] = 0;
      nxt_err[j] = 0;
    end
    col_cnt = 0;
    row_cnt = 0;
    set_mode(0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity gamma so that no entry is read before it is loaded
    for (int j = 0; j < 256; j++) send_beat(tbl(8'(j), 8'(j)));

    dir_beat = '{pix(8'd0), pix(8'd255), pix(8'd128), pix(8'd127),
                 tbl(8'd0, 8'd0), tbl(8'd255, 8'd255), pix(8'd255), pix(8'd0),
                 pix(8'd1), pix(8'd254), pix(8'd64), pix(8'd192)};
    dir_has  = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    dir_exp  = new[dir_beat.size()];
    foreach (dir_exp[j]) dir_exp[j] = '0;
    dir_exp[1].pixel_out = PIX_MAX;
    dir_exp[2].pixel_out = PIX_MAX;
    foreach (dir_beat[j]) send_beat(dir_beat[j], dir_has[j], dir_exp[j]);

    // row ends, frame end, negative error clamp under a tiny frame
    write_reg(CFG_LEVEL_BITS, 13'd2);
    write_reg(CFG_LINE_WIDTH, 13'd3);
    write_reg(CFG_FRAME_HEIGHT, 13'd2);
    foreach (dir_beat[j]) if (dir_beat[j].op == OP_PIXEL) send_beat(dir_beat[j]);

    foreach (phase_cfg[p]) begin
      write_reg(CFG_LEVEL_BITS, CFG_W'(phase_cfg[p][0]));
      write_reg(CFG_LINE_WIDTH, CFG_W'(phase_cfg[p][1]));
      write_reg(CFG_FRAME_HEIGHT, CFG_W'(phase_cfg[p][2]));
      set_mode(phase_cfg[p][4]);
      for (int j = 0; j < phase_cfg[p][3]; j++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          b = tbl(8'($urandom), 8'($urandom));
        end else if (r < 25) begin
          b = pix($urandom_range(1) ? 8'd255 : 8'd0);
          b.table_index = 8'($urandom);
          b.table_value = 8'($urandom);
        end else begin
          b = pix(8'($urandom));
          b.table_index = 8'($urandom);
          b.table_value = 8'($urandom);
        end
        send_beat(b);
      end
    end
    in_valid <= 1'b0;
    set_mode(0);

    while (expected_pix.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("error_diffusion_quantizer_top regression: pass");
    end else begin
      $display("error_diffusion_quantizer_top regression: fail");
    end
    $finish;
  end

endmodule
